// ===== rtl/core/dqu_pkg.sv =====
// Shared types and constants for the double-ended queue unit.
package dqu_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FRONT      = 3'd4,
    CMD_BACK       = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;
  } out_word_t;

endpackage

// ===== rtl/core/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: circular word store, pointers and result register.
//
// Bounded double-ended queue of signed 32-bit words held in one synchronous
// memory of DEPTH entries. Present a command word on in_word and raise start;
// the command is taken at any clock edge where start is high and busy is low.
// busy never rises, so a new command may be issued every cycle. Each command
// returns exactly one result word on out_word, marked by out_valid for a single
// cycle, in the cycle after the command was taken; the receiver must capture it
// then, it cannot hold the result off. A command touches at most one memory
// entry, either one write (push) or one read (pop or peek), and the head
// pointer and word count update in the same cycle, which sets the rate at one
// command per clock. Reads of popped or peeked words come straight from the
// memory's registered read port. Popping or peeking an empty queue reports
// an empty error; pushing into a full store is refused with a full error and
// leaves the queue unchanged. The count field carries the word count after the
// command, reduced to its low 7 bits. Clear resets head and count but leaves
// the stored words in place; no clearing pass is needed after reset.
module double_ended_queue_unit
  import dqu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 2;

  // Word store, written by pushes and read by pops and peeks.
  logic [DATA_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]  head_r,  head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r;
  status_t           status_r,  status_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic              sel_mem_r, sel_mem_nxt;
  logic [DATA_W-1:0] rd_data_r;

  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic              wr_en;
  logic              rd_en;
  logic [PTR_W-1:0]  addr;
  logic [CNT_W-1:0]  off;
  logic [SUM_W-1:0]  sum;
  logic [PTR_W-1:0]  slot;
  logic [PTR_W-1:0]  head_dec;
  logic [PTR_W-1:0]  head_inc;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  // The queue never stalls a command.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));

  // Slot at an offset from the head, wrapped once (offset stays below DEPTH wherever the slot is used).
  always_comb begin
    unique case (in_word.command)
      CMD_PUSH_BACK:             off = count_r;
      CMD_POP_BACK, CMD_BACK:    off = count_r - CNT_W'(1);
      default:                   off = CNT_W'(1);
    endcase
    sum = SUM_W'(head_r) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    slot = sum[PTR_W-1:0];
  end

  assign head_inc = slot;
  assign head_dec = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - PTR_W'(1);

  // Decode the command: pick the memory access, next pointers and status.
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    sel_mem_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    addr        = head_r;
    unique case (in_word.command)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          addr      = head_dec;
          wr_en     = accept;
          head_nxt  = head_dec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          addr      = slot;
          wr_en     = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt  = ST_VALUE;
          sel_mem_nxt = 1'b1;
          addr        = head_r;
          rd_en       = accept;
          if (in_word.command == CMD_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      CMD_POP_BACK, CMD_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt  = ST_VALUE;
          sel_mem_nxt = 1'b1;
          addr        = slot;
          rd_en       = accept;
          if (in_word.command == CMD_POP_BACK) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      CMD_SIZE: begin
        status_nxt = ST_OK;
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Report the low 7 bits of the count, zero-extended for small stores.
  assign count_wide = (CNT_W + COUNT_W)'(count_nxt);

  // Memory port: one write or one registered read per command, never both.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= in_word.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Pointers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Result payload holds until the next command; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      sel_mem_r   <= sel_mem_nxt;
      out_count_r <= count_wide[COUNT_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_word.status     = status_r;
  assign out_word.read_value = sel_mem_r ? rd_data_r : '0;
  assign out_word.count      = out_count_r;

endmodule

// ===== rtl/core/dqu_checker.sv =====
// Port-level assertions for the double-ended queue unit, bound to its top level.
module dqu_checker
  import dqu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // Every taken command gives one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("dqu: taken command gave no result");

  // No result appears without a command.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("dqu: result without a command");

  // Empty error leaves the queue empty and carries no word.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_EMPTY) |->
      (out_word.read_value == '0 && out_word.count == '0))
    else $error("dqu: empty error with data or nonzero count");

  // Only value results carry a word.
  a_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == ST_OK || out_word.status == ST_FULL)) |->
      out_word.read_value == '0)
    else $error("dqu: word returned with non-value status");

  // Clear drops the count to zero with an ok status.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.command == CMD_CLEAR) |=>
      (out_word.count == '0 && out_word.status == ST_OK))
    else $error("dqu: clear did not empty the queue");

endmodule

bind double_ended_queue_unit dqu_checker #(.DEPTH(DEPTH)) u_dqu_checker (.*);

// ===== tb/dq_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the result words of the deque unit.
package dq_scoreboard_pkg;
  import dqu_pkg::*;

  localparam int unsigned SLOT_W       = $clog2(DEPTH_DEF);
  localparam int unsigned REPORT_LIMIT = 10;

  class dq_scoreboard;
    // Mirror of the circular store, head position and word count.
    logic [DATA_W-1:0]  slots [DEPTH_DEF];
    bit   [SLOT_W-1:0]  head_pos;
    bit   [COUNT_W-1:0] word_count;
    // Result words still due from the block, oldest first.
    out_word_t          due_words [$];
    cmd_t               due_cmds  [$];
    int unsigned        mismatches;

    function bit [SLOT_W-1:0] slot_after(bit [COUNT_W-1:0] off);
      return head_pos + off[SLOT_W-1:0];
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("mismatch %0d: %s", mismatches, msg);
      end
    endfunction

    // Apply one accepted command to the mirror and queue the result word it yields.
    function void note_command(in_word_t w);
      out_word_t r;
      r.status     = ST_OK;
      r.read_value = '0;
      case (w.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (word_count == COUNT_W'(DEPTH_DEF)) begin
            r.status = ST_FULL;
          end else begin
            if (w.command == CMD_PUSH_FRONT) begin
              head_pos        = head_pos - 1'b1;
              slots[head_pos] = w.value;
            end else begin
              slots[slot_after(word_count)] = w.value;
            end
            word_count = word_count + 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_FRONT: begin
          if (word_count == '0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status     = ST_VALUE;
            r.read_value = slots[head_pos];
            if (w.command == CMD_POP_FRONT) begin
              head_pos   = head_pos + 1'b1;
              word_count = word_count - 1'b1;
            end
          end
        end
        CMD_POP_BACK, CMD_BACK: begin
          if (word_count == '0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status     = ST_VALUE;
            r.read_value = slots[slot_after(word_count - 1'b1)];
            if (w.command == CMD_POP_BACK) begin
              word_count = word_count - 1'b1;
            end
          end
        end
        CMD_SIZE: begin
        end
        default: begin
          head_pos   = '0;
          word_count = '0;
        end
      endcase
      r.count = word_count;
      due_words.insert(due_words.size(), r);
      due_cmds.insert(due_cmds.size(), w.command);
    endfunction

    // Compare one result word with the oldest one due.
    function void check_result(out_word_t got);
      out_word_t want;
      cmd_t      c;
      if (due_words.size() == 0) begin
        note_mismatch($sformatf("result with none due: status=%0d read_value=%h count=%0d",
                                got.status, got.read_value, got.count));
        return;
      end
      want = due_words[0];
      c    = due_cmds[0];
      due_words.delete(0);
      due_cmds.delete(0);
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.count !== want.count) begin
        note_mismatch($sformatf({"%s: expected status=%0d read_value=%h count=%0d,",
                                 " got status=%0d read_value=%h count=%0d"},
                                c.name(), want.status, want.read_value, want.count,
                                got.status, got.read_value, got.count));
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the double-ended queue unit: directed and random command words.
module tb_double_ended_queue_unit;
  import dqu_pkg::*;
  import dq_scoreboard_pkg::*;

  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      start    = 1'b0;
  in_word_t  in_word  = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  dq_scoreboard sb = new;

  int unsigned sender_idle_pct = 0;
  int unsigned words_sent      = 0;
  int unsigned cycles          = 0;

  double_ended_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: every signal here is driven by nonblocking assignments, so the values
  // read at the edge are the ones the block itself sees. Note the accepted command
  // before checking, so a result in the same cycle would still find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0) begin
        sb.note_command(in_word);
      end
      if (out_valid === 1'b1) begin
        sb.check_result(out_word);
      end
    end
  end

  // Pick a word: extremes often, otherwise fully random bits.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return {1'b0, {(DATA_W-1){1'b1}}};
      1:       return {1'b1, {(DATA_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Send one command word. Idle the sender for a random stretch first, then hold
  // start high until an edge with busy low takes the word. Leave start high on
  // return so back-to-back words need no second assignment in the same step.
  task automatic issue(input cmd_t c, input logic [DATA_W-1:0] v);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= '{command: c, value: v};
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
  endtask

  task automatic push_any();
    issue($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word());
  endtask

  task automatic pop_any();
    issue($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, rand_word());
  endtask

  // Push until the store is full, then push a few more to hit the full error.
  task automatic fill_up();
    int unsigned n;
    n = DEPTH_DEF - sb.word_count + $urandom_range(4, 2);
    repeat (n) push_any();
  endtask

  // Pop until empty, then pop a few more to hit the empty error.
  task automatic drain_out();
    int unsigned n;
    n = sb.word_count + $urandom_range(3, 1);
    repeat (n) pop_any();
  endtask

  // One random command; lean toward pushes when the queue runs low and toward
  // pops when it runs high so that the count wanders over its whole range.
  task automatic random_command();
    int unsigned roll;
    int unsigned push_w;
    roll   = $urandom_range(99);
    push_w = (sb.word_count < 16) ? 55 : (sb.word_count > 48) ? 25 : 40;
    if (roll < push_w) begin
      push_any();
    end else if (roll < push_w + 30) begin
      pop_any();
    end else if (roll < 97) begin
      issue(cmd_t'($urandom_range(CMD_SIZE, CMD_FRONT)), rand_word());
    end else begin
      issue(CMD_CLEAR, rand_word());
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned roll;

    // Hold reset, then release it at an edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty errors on every read command and size of an empty queue.
    issue(CMD_SIZE, '0);
    issue(CMD_POP_FRONT, '1);
    issue(CMD_POP_BACK, '1);
    issue(CMD_FRONT, '0);
    issue(CMD_BACK, '0);
    // Extremes at both ends, peeks and pops from both ends, then empty again.
    issue(CMD_PUSH_BACK, 32'h7fff_ffff);
    issue(CMD_PUSH_FRONT, 32'h8000_0000);
    issue(CMD_FRONT, '0);
    issue(CMD_BACK, '0);
    issue(CMD_PUSH_BACK, '0);
    issue(CMD_PUSH_FRONT, '1);
    issue(CMD_SIZE, '1);
    issue(CMD_POP_BACK, '0);
    issue(CMD_POP_FRONT, '0);
    issue(CMD_FRONT, '0);
    issue(CMD_BACK, '0);
    issue(CMD_POP_FRONT, '0);
    issue(CMD_POP_BACK, '0);
    issue(CMD_POP_FRONT, '0);
    // Clear keeps stored words but resets head and count; reads after it are empty.
    issue(CMD_PUSH_BACK, 32'h5a5a_5a5a);
    issue(CMD_PUSH_FRONT, 32'ha5a5_a5a5);
    issue(CMD_CLEAR, 32'h1234_5678);
    issue(CMD_SIZE, '0);
    issue(CMD_BACK, '0);
    // Push front from head zero wraps to the last slot; read it back from the back.
    issue(CMD_PUSH_FRONT, 32'h0000_0001);
    issue(CMD_BACK, '0);

    // Random: three sender idling phases of equal length.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 66 : 0;
      target          = words_sent + RANDOM_WORDS / 3;
      // Run one full fill and drain early so both errors and the wrap are covered.
      if (phase == 0) begin
        fill_up();
        drain_out();
      end
      while (words_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          fill_up();
        end else if (roll < 12) begin
          drain_out();
        end else begin
          random_command();
        end
      end
    end

    // Drop start, wait for every result due, then give stray results time to show.
    start <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
